@@ rtl/cce_pkg.sv @@
// ----------------------------------------------------------------------------
// cce_pkg: shared types and constants of the configurable crc engine
// item layouts, register indexes, width codes and the configuration bundle
// ----------------------------------------------------------------------------
package cce_pkg;

   localparam int unsigned CSR_INDEX_WIDTH = 3;
   localparam int unsigned CSR_DATA_WIDTH  = 32;
   localparam int unsigned CRC_WIDTH       = 32;

   typedef logic [CSR_INDEX_WIDTH-1:0] csr_index_type;

   localparam csr_index_type CSR_POLYNOMIAL     = 3'd0;
   localparam csr_index_type CSR_INITIAL_VALUE  = 3'd1;
   localparam csr_index_type CSR_WIDTH_CODE     = 3'd2;
   localparam csr_index_type CSR_REFLECT_INPUT  = 3'd3;
   localparam csr_index_type CSR_REFLECT_OUTPUT = 3'd4;
   localparam csr_index_type CSR_FINAL_XOR      = 3'd5;

   typedef enum logic [1:0] {
      WIDTH_32 = 2'd0,
      WIDTH_16 = 2'd1,
      WIDTH_8  = 2'd2,
      WIDTH_7  = 2'd3
   } width_code_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       first_byte;
      logic       last_byte;
   } req_item_type;

   typedef struct packed {
      logic [CRC_WIDTH-1:0] crc_value;
      logic                 message_done;
   } rsp_item_type;

   typedef struct packed {
      logic [CRC_WIDTH-1:0] polynomial;
      logic [CRC_WIDTH-1:0] initial_value;
      width_code_type       width_code;
      logic                 reflect_input;
      logic                 reflect_output;
      logic [CRC_WIDTH-1:0] final_xor;
   } cfg_type;

endpackage

@@ rtl/configurable_crc_engine.sv @@
// ----------------------------------------------------------------------------
// configurable_crc_engine: byte-wide parametric crc with 32/16/8/7 bit widths
// item path: accept, then input reg, then result reg, then rsp_valid
// throughput: 1 item per cycle while rsp_ready holds, set by the crc register loop through the fold
// reset: sync active high, config to crc-32/mpeg-2 defaults, crc register to zero
// ----------------------------------------------------------------------------
module configurable_crc_engine (
   input  logic                                clock,
   input  logic                                reset,
   // item input
   input  logic                                req_valid,
   output logic                                req_ready,
   input  cce_pkg::req_item_type               req_data,
   // result output
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output cce_pkg::rsp_item_type               rsp_data,
   // register writes
   input  logic                                csr_write_en,
   input  cce_pkg::csr_index_type              csr_index,
   input  logic [cce_pkg::CSR_DATA_WIDTH-1:0]  csr_wdata
);
   import cce_pkg::*;

   // configuration registers
   cfg_type cfg_ff;
   cfg_type cfg_in;

   // running crc state
   logic [CRC_WIDTH-1:0] crc_ff;
   logic [CRC_WIDTH-1:0] crc_fold;

   // input stage
   logic         s1_valid_ff;
   logic         s1_valid_in;
   req_item_type s1_item_ff;

   // result stage
   logic         out_valid_ff;
   logic         out_valid_in;
   rsp_item_type out_item_ff;
   rsp_item_type fold_result;

   logic req_fire;
   logic s1_fire;
   logic out_free;

   // result register empties or drains this cycle
   assign out_free  = !out_valid_ff || rsp_ready;
   // input stage moves forward whenever the result register can take it
   assign s1_fire   = s1_valid_ff && out_free;
   // input stage can refill if empty or if its item leaves now
   assign req_ready = !s1_valid_ff || out_free;
   assign req_fire  = req_valid && req_ready;

   assign s1_valid_in  = req_fire ? 1'b1 : (s1_fire ? 1'b0 : s1_valid_ff);
   assign out_valid_in = s1_fire ? 1'b1 : (rsp_ready ? 1'b0 : out_valid_ff);

   // register write decode, unknown indexes dropped
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         unique case (csr_index)
            CSR_POLYNOMIAL:     cfg_in.polynomial     = csr_wdata;
            CSR_INITIAL_VALUE:  cfg_in.initial_value  = csr_wdata;
            CSR_WIDTH_CODE:     cfg_in.width_code     = width_code_type'(csr_wdata[1:0]);
            CSR_REFLECT_INPUT:  cfg_in.reflect_input  = csr_wdata[0];
            CSR_REFLECT_OUTPUT: cfg_in.reflect_output = csr_wdata[0];
            CSR_FINAL_XOR:      cfg_in.final_xor      = csr_wdata;
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.polynomial     <= 32'h04C1_1DB7;
         cfg_ff.initial_value  <= 32'hFFFF_FFFF;
         cfg_ff.width_code     <= WIDTH_32;
         cfg_ff.reflect_input  <= 1'b0;
         cfg_ff.reflect_output <= 1'b0;
         cfg_ff.final_xor      <= 32'h0000_0000;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // fold logic sits between the input register and the result register
   cce_byte_fold u_fold (
      .cfg       (cfg_ff),
      .crc_state (crc_ff),
      .item      (s1_item_ff),
      .crc_next  (crc_fold),
      .result    (fold_result)
   );

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         crc_ff       <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
         // crc state commits together with the result it produced
         if (s1_fire) begin
            crc_ff <= crc_fold;
         end
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_item_ff <= req_data;
      end
      if (s1_fire) begin
         out_item_ff <= fold_result;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_item_ff;

   // crc state moves only when an item passes into the result register
   assert property (@(posedge clock) disable iff (reset)
      !s1_fire |=> $stable(crc_ff))
      else $error("crc state changed without an item advancing");

   // a result appears only after an item sat in the input stage
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(s1_valid_ff))
      else $error("result raised without a staged item");

   // an empty result register never blocks input
   assert property (@(posedge clock) disable iff (reset)
      !out_valid_ff |-> req_ready)
      else $error("input stalled while result register empty");

endmodule

@@ rtl/cce_byte_fold.sv @@
// ----------------------------------------------------------------------------
// cce_byte_fold: one byte folded into the crc register
// eight unrolled shift/xor steps, then output reflection and final xor
// ----------------------------------------------------------------------------
module cce_byte_fold (
   input  cce_pkg::cfg_type                 cfg,
   input  logic [cce_pkg::CRC_WIDTH-1:0]    crc_state,
   input  cce_pkg::req_item_type            item,
   output logic [cce_pkg::CRC_WIDTH-1:0]    crc_next,
   output cce_pkg::rsp_item_type            result
);
   import cce_pkg::*;

   logic [CRC_WIDTH-1:0] mask;
   logic [4:0]           top_idx;
   logic [CRC_WIDTH-1:0] reflected;

   function automatic logic [7:0] rev8(input logic [7:0] v);
      logic [7:0] r;
      for (int i = 0; i < 8; i++) begin
         r[i] = v[7-i];
      end
      return r;
   endfunction

   function automatic logic [CRC_WIDTH-1:0] rev32(input logic [CRC_WIDTH-1:0] v);
      logic [CRC_WIDTH-1:0] r;
      for (int i = 0; i < CRC_WIDTH; i++) begin
         r[i] = v[CRC_WIDTH-1-i];
      end
      return r;
   endfunction

   // width decode
   always_comb begin
      unique case (cfg.width_code)
         WIDTH_32: begin
            mask    = 32'hFFFF_FFFF;
            top_idx = 5'd31;
         end
         WIDTH_16: begin
            mask    = 32'h0000_FFFF;
            top_idx = 5'd15;
         end
         WIDTH_8: begin
            mask    = 32'h0000_00FF;
            top_idx = 5'd7;
         end
         WIDTH_7: begin
            mask    = 32'h0000_007F;
            top_idx = 5'd6;
         end
         default: begin
            mask    = 32'hFFFF_FFFF;
            top_idx = 5'd31;
         end
      endcase
   end

   // msb-first bitwise fold
   always_comb begin
      logic [CRC_WIDTH-1:0] crc;
      logic [CRC_WIDTH-1:0] poly;
      logic [7:0]           data;
      logic                 in_bit;
      logic                 msb;
      poly = cfg.polynomial & mask;
      crc  = (item.first_byte ? cfg.initial_value : crc_state) & mask;
      data = cfg.reflect_input ? rev8(item.data_byte) : item.data_byte;
      for (int i = 0; i < 8; i++) begin
         in_bit = data[7-i];
         msb    = crc[top_idx];
         crc    = (crc << 1) & mask;
         if (in_bit != msb) begin
            crc = crc ^ poly;
         end
      end
      crc_next = crc;
   end

   // reverse over the active width: full reversal, then drop the unused low end
   always_comb begin
      logic [CRC_WIDTH-1:0] full;
      full = rev32(crc_next);
      unique case (cfg.width_code)
         WIDTH_32: reflected = full;
         WIDTH_16: reflected = full >> 16;
         WIDTH_8:  reflected = full >> 24;
         WIDTH_7:  reflected = full >> 25;
         default:  reflected = full;
      endcase
   end

   assign result.crc_value    = ((cfg.reflect_output ? reflected : crc_next) ^ cfg.final_xor)
                                & mask;
   assign result.message_done = item.last_byte;

endmodule

@@ bench/tb_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the configurable crc engine
// drives byte items through the valid/ready input, predicts every crc result
// with its own bitwise fold and compares each result item in order; the
// register setup changes between phases while the engine is idle
// ----------------------------------------------------------------------------
module tb_top;
   import cce_pkg::*;

   // clock, reset and all engine inputs start at known values
   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_ready;
   req_item_type              req_data = '0;
   logic                      rsp_valid;
   logic                      rsp_ready = 1'b0;
   rsp_item_type              rsp_data;
   logic                      csr_write_en = 1'b0;
   csr_index_type             csr_index = CSR_POLYNOMIAL;
   logic [CSR_DATA_WIDTH-1:0] csr_wdata = '0;

   // bytes waiting to be driven and crc results still owed by the engine
   req_item_type byte_queue[$];
   rsp_item_type crc_expected[$];

   // predictor state: register copy and running crc, as after reset
   cfg_type     model_cfg;
   logic [31:0] model_crc = '0;

   int unsigned sender_idle_pct   = 32;
   int unsigned receiver_idle_pct = 80;
   int unsigned mismatch_count    = 0;

   configurable_crc_engine uut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_data     (req_data),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_data     (rsp_data),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // fold one byte into the running crc and return the finished value
   function automatic rsp_item_type fold_byte(req_item_type item);
      int unsigned  w;
      logic [31:0]  mask;
      logic [31:0]  top;
      logic [31:0]  poly;
      logic [31:0]  crc;
      logic [31:0]  finished;
      logic [7:0]   data;
      logic         msb;
      rsp_item_type result;
      case (model_cfg.width_code)
         WIDTH_32: w = 32;
         WIDTH_16: w = 16;
         WIDTH_8:  w = 8;
         default:  w = 7;
      endcase
      mask = (w == 32) ? 32'hFFFF_FFFF : ((32'd1 << w) - 32'd1);
      top  = 32'd1 << (w - 1);
      poly = model_cfg.polynomial & mask;
      // first byte restarts from the initial value, otherwise keep going
      if (item.first_byte)
         model_crc = model_cfg.initial_value;
      crc  = model_crc & mask;
      data = item.data_byte;
      if (model_cfg.reflect_input)
         for (int i = 0; i < 8; i++)
            data[i] = item.data_byte[7-i];
      // msb-first fold, one bit at a time, same rule for every width
      for (int i = 0; i < 8; i++) begin
         msb = |(crc & top);
         crc = (crc << 1) & mask;
         if (data[7-i] != msb)
            crc = crc ^ poly;
      end
      model_crc = crc;
      finished  = crc;
      if (model_cfg.reflect_output) begin
         finished = '0;
         for (int i = 0; i < 32; i++)
            if (i < w)
               finished[w-1-i] = crc[i];
      end
      result.crc_value    = (finished ^ model_cfg.final_xor) & mask;
      result.message_done = item.last_byte;
      return result;
   endfunction

   // driver: hold an item until taken, then maybe idle, then send the next
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         // prediction happens at the edge where the engine takes the byte
         if (req_valid && req_ready)
            crc_expected.push_back(fold_byte(req_data));
         if (req_valid && !req_ready) begin
            // stalled: valid and payload stay as they are
         end else if (byte_queue.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
            req_valid <= 1'b1;
            req_data  <= byte_queue.pop_front();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // monitor: every taken result is matched against the oldest prediction
   always @(posedge clock) begin
      rsp_item_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (crc_expected.size() == 0) begin
               mismatch_count++;
               $display("%0t: unexpected result item, expected none, actual crc %h done %b",
                        $time, rsp_data.crc_value, rsp_data.message_done);
            end else begin
               want = crc_expected.pop_front();
               if (rsp_data.crc_value !== want.crc_value) begin
                  mismatch_count++;
                  $display("%0t: crc_value mismatch, expected %h, actual %h",
                           $time, want.crc_value, rsp_data.crc_value);
               end
               if (rsp_data.message_done !== want.message_done) begin
                  mismatch_count++;
                  $display("%0t: message_done mismatch, expected %b, actual %b",
                           $time, want.message_done, rsp_data.message_done);
               end
            end
         end
         rsp_ready <= ($urandom_range(99) >= receiver_idle_pct);
      end
   end

   task automatic send_byte(input logic [7:0] data, input logic first, input logic last);
      req_item_type item;
      item.data_byte  = data;
      item.first_byte = first;
      item.last_byte  = last;
      byte_queue.push_back(item);
   endtask

   // wait until every byte is taken and every result has come back
   task automatic drain();
      while (byte_queue.size() != 0 || req_valid || crc_expected.size() != 0)
         @(negedge clock);
   endtask

   // one register write, mirrored into the predictor once the engine has it
   task automatic write_csr(input csr_index_type index, input logic [31:0] value);
      @(posedge clock);
      csr_write_en <= 1'b1;
      csr_index    <= index;
      csr_wdata    <= value;
      @(posedge clock);
      csr_write_en <= 1'b0;
      case (index)
         CSR_POLYNOMIAL:     model_cfg.polynomial     = value;
         CSR_INITIAL_VALUE:  model_cfg.initial_value  = value;
         CSR_WIDTH_CODE:     model_cfg.width_code     = width_code_type'(value[1:0]);
         CSR_REFLECT_INPUT:  model_cfg.reflect_input  = value[0];
         CSR_REFLECT_OUTPUT: model_cfg.reflect_output = value[0];
         CSR_FINAL_XOR:      model_cfg.final_xor      = value;
         default: ;
      endcase
   endtask

   task automatic load_config(input logic [31:0] poly, input logic [31:0] init,
                              input logic [31:0] wcode, input logic [31:0] refl_in,
                              input logic [31:0] refl_out, input logic [31:0] xor_out);
      write_csr(CSR_POLYNOMIAL, poly);
      write_csr(CSR_INITIAL_VALUE, init);
      write_csr(CSR_WIDTH_CODE, wcode);
      write_csr(CSR_REFLECT_INPUT, refl_in);
      write_csr(CSR_REFLECT_OUTPUT, refl_out);
      write_csr(CSR_FINAL_XOR, xor_out);
   endtask

   // random register value: zero or all ones a quarter of the time each, else anything
   function automatic logic [31:0] pick_word();
      case ($urandom_range(3))
         0:       return 32'h0000_0000;
         1:       return 32'hFFFF_FFFF;
         default: return $urandom;
      endcase
   endfunction

   // stimulus: directed bytes first, then phases of random messages
   initial begin
      int unsigned count;
      int unsigned len;
      logic        broken;
      // crc-32/mpeg-2 defaults that the engine comes out of reset with
      model_cfg.polynomial     = 32'h04C1_1DB7;
      model_cfg.initial_value  = 32'hFFFF_FFFF;
      model_cfg.width_code     = WIDTH_32;
      model_cfg.reflect_input  = 1'b0;
      model_cfg.reflect_output = 1'b0;
      model_cfg.final_xor      = 32'h0000_0000;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // bytes before any first byte fold into the zero register
      send_byte(8'h00, 1'b0, 1'b0);
      send_byte(8'hFF, 1'b0, 1'b0);
      // the usual check string
      for (int i = 0; i < 9; i++)
         send_byte(8'(8'h31 + i), i == 0, i == 8);
      // after a last byte the crc simply keeps running
      send_byte(8'hA5, 1'b0, 1'b0);
      // one-byte message with both flags
      send_byte(8'h80, 1'b1, 1'b1);
      // width change in the middle of a message
      send_byte(8'h01, 1'b1, 1'b0);
      send_byte(8'hFE, 1'b0, 1'b0);
      drain();
      write_csr(CSR_WIDTH_CODE, 32'(WIDTH_7));
      send_byte(8'h7F, 1'b0, 1'b0);
      send_byte(8'h80, 1'b0, 1'b1);
      // every width with both reflections and all-ones polynomial and xor
      for (int w = 0; w < 4; w++) begin
         drain();
         load_config(32'hFFFF_FFFF, 32'h0000_0000, 32'(w), 32'd1, 32'd1, 32'hFFFF_FFFF);
         send_byte(8'h00, 1'b1, 1'b0);
         send_byte(8'hFF, 1'b0, 1'b1);
      end

      // twelve random phases: sender busy first, then receiver busy, then no idling
      for (int phase = 0; phase < 12; phase++) begin
         drain();
         case (phase / 4)
            0: begin
               sender_idle_pct   = 32;
               receiver_idle_pct = 80;
            end
            1: begin
               sender_idle_pct   = 80;
               receiver_idle_pct = 32;
            end
            default: begin
               sender_idle_pct   = 0;
               receiver_idle_pct = 0;
            end
         endcase
         // narrow registers get junk in the unused upper bits
         load_config(pick_word(), pick_word(),
                     ($urandom & 32'hFFFF_FFFC) | ((phase < 4) ? phase : $urandom_range(3)),
                     ($urandom & 32'hFFFF_FFFE) | $urandom_range(1),
                     ($urandom & 32'hFFFF_FFFE) | $urandom_range(1),
                     pick_word());
         count = 0;
         while (count < 120) begin
            if ($urandom_range(99) < 15) begin
               // noise: any flags at all
               send_byte(8'($urandom), 1'($urandom_range(1)), 1'($urandom_range(1)));
               count++;
            end else begin
               // framed message, now and then with its last byte flag missing
               len    = $urandom_range(12, 1);
               broken = ($urandom_range(9) == 0);
               for (int j = 0; j < len; j++)
                  send_byte(8'($urandom), j == 0, (j == len - 1) && !broken);
               count += len;
            end
         end
      end

      drain();
      // room for any stray result still held in the engine's registers
      repeat (10) @(posedge clock);
      if (mismatch_count == 0 && crc_expected.size() == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

   // watchdog far beyond the slowest legal run
   initial begin
      #4_000_000;
      $display("CHECK FAILED");
      $finish;
   end

endmodule

@@ filelist.f @@
rtl/cce_pkg.sv
rtl/cce_byte_fold.sv
rtl/configurable_crc_engine.sv
bench/tb_top.sv
